// ===== rtl/core/hwcd_pkg.sv =====
// Shared types, sizes and helpers for the wait-for graph cycle detector.
// Used by hwcd_dfs and hierarchical_waitfor_cycle_detect_core; depends on nothing.
package hwcd_pkg;

   // Graph size and the widths that follow from it.
   localparam int NODES  = 16;
   localparam int NODE_W = $clog2(NODES);
   localparam int CNT_W  = $clog2(NODES + 1);

   // Verdict scope codes.
   localparam logic SCOPE_REGION = 1'b0;
   localparam logic SCOPE_GLOBAL = 1'b1;

   // One input beat: one adjacency row of the current region.
   typedef struct packed {
      logic [NODE_W-1:0] row_index;
      logic [NODES-1:0]  row_bits;
      logic [CNT_W-1:0]  node_count;
      logic              last_row_of_region;
      logic              last_region;
   } req_type;

   // One result beat: a region or global verdict.
   typedef struct packed {
      logic scope;
      logic deadlock;
      logic last;
   } rsp_type;

   // Command from the controller to the search engine.
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] size;
   } dfs_cmd_type;

   // Status and row fetch address from the search engine.
   typedef struct packed {
      logic              done;
      logic              found;
      logic [NODE_W-1:0] rd_addr;
   } dfs_sts_type;

   // Mask with the lowest n bits set.
   function automatic logic [NODES-1:0] low_mask(input logic [CNT_W-1:0] n);
      logic [NODES-1:0] m;
      for (int i = 0; i < NODES; i++) begin
         m[i] = (CNT_W'(i) < n);
      end
      return m;
   endfunction

endpackage

// ===== rtl/core/hierarchical_waitfor_cycle_detect_core.sv =====
// Top level of the hierarchical wait-for graph deadlock detector.
// Holds the region and global graph memories and the controller; uses hwcd_pkg and hwcd_dfs.
//
// Usage:
//   Each request beat carries one adjacency row of the current region. Rows at or
//   beyond node_count are dropped and bits at or beyond node_count are masked off.
//   A beat without last_row_of_region produces no response and leaves req_stall low.
//   A beat with last_row_of_region starts a depth-first search of the region graph
//   (n = min(node_count, 16) nodes) and yields one response beat with scope 0.
//   A deadlocked region is ORed into the global graph, one row per cycle.
//   With last_region also set, the global graph is then searched over all 16 nodes
//   and a second beat with scope 1 follows; last marks the final beat of the request.
// Search and stalls:
//   The search examines one neighbour per cycle except while it waits on a row fetch
//   from the graph memory. req_stall is high while a closing beat is being worked on.
// Reset clears both graphs at once through per-row valid bits; no clearing pass.
// A stalled response holds in its output register; a new request may still be taken,
// and the next verdict waits until that register is empty or is being read out.
module hierarchical_waitfor_cycle_detect_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hwcd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hwcd_pkg::rsp_type rsp_payload
);

   localparam logic [1:0] T_IDLE  = 2'd0;
   localparam logic [1:0] T_CHECK = 2'd1;
   localparam logic [1:0] T_MERGE = 2'd2;
   localparam logic [1:0] T_EMIT  = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [hwcd_pkg::CNT_W-1:0]   n_ff, n_in;
   logic                         scope_ff, scope_in;
   logic                         close_all_ff, close_all_in;
   logic                         dl_ff, dl_in;
   logic [hwcd_pkg::CNT_W-1:0]   mu_ff, mu_in;
   logic                         m_pend_ff, m_pend_in;
   logic [hwcd_pkg::NODE_W-1:0]  m_addr_ff, m_addr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   hwcd_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [hwcd_pkg::NODES-1:0]   region_mem [hwcd_pkg::NODES];
   logic [hwcd_pkg::NODES-1:0]   global_mem [hwcd_pkg::NODES];
   logic [hwcd_pkg::NODES-1:0]   reg_vld_ff;
   logic [hwcd_pkg::NODES-1:0]   glb_vld_ff;
   logic [hwcd_pkg::NODES-1:0]   reg_rd_ff;
   logic [hwcd_pkg::NODES-1:0]   glb_rd_ff;
   logic                         reg_rv_ff;
   logic                         glb_rv_ff;

   logic                         accept;
   logic [hwcd_pkg::CNT_W-1:0]   n_eff;
   logic                         reg_we;
   logic [hwcd_pkg::NODES-1:0]   reg_wdata;
   logic                         glb_we;
   logic [hwcd_pkg::NODES-1:0]   glb_wdata;
   logic                         reg_clr;
   logic                         glb_clr;
   logic                         emit_go;
   logic [hwcd_pkg::NODE_W-1:0]  rd_addr;
   logic [hwcd_pkg::NODES-1:0]   reg_row;
   logic [hwcd_pkg::NODES-1:0]   glb_row;
   logic [hwcd_pkg::NODES-1:0]   dfs_row;
   hwcd_pkg::dfs_cmd_type        cmd;
   hwcd_pkg::dfs_sts_type        sts;

   // Request side: effective size and the row write.
   assign req_stall = (state_ff != T_IDLE);
   assign accept    = req_valid && !req_stall;
   assign n_eff     = (req_payload.node_count > hwcd_pkg::CNT_W'(hwcd_pkg::NODES)) ?
                      hwcd_pkg::CNT_W'(hwcd_pkg::NODES) : req_payload.node_count;
   assign reg_we    = accept && ({1'b0, req_payload.row_index} < n_eff);
   assign reg_wdata = req_payload.row_bits & hwcd_pkg::low_mask(n_eff);

   // Rows whose valid bit is clear read as zero.
   assign reg_row = reg_rv_ff ? reg_rd_ff : '0;
   assign glb_row = glb_rv_ff ? glb_rd_ff : '0;
   assign dfs_row = (scope_ff == hwcd_pkg::SCOPE_GLOBAL) ? glb_row : reg_row;

   // Merge write data: region row of the pending address ORed into the global row.
   assign glb_wdata = glb_row | (reg_row & hwcd_pkg::low_mask(n_ff));

   // The merge sweep owns the read port while it runs.
   assign rd_addr = (state_ff == T_MERGE) ? mu_ff[hwcd_pkg::NODE_W-1:0] : sts.rd_addr;

   assign emit_go = (state_ff == T_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // Controller.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      scope_in     = scope_ff;
      close_all_in = close_all_ff;
      dl_in        = dl_ff;
      mu_in        = mu_ff;
      m_pend_in    = 1'b0;
      m_addr_in    = m_addr_ff;
      glb_we       = 1'b0;
      reg_clr      = 1'b0;
      glb_clr      = 1'b0;
      cmd.start    = 1'b0;
      cmd.size     = n_eff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept && req_payload.last_row_of_region) begin
               n_in         = n_eff;
               close_all_in = req_payload.last_region;
               scope_in     = hwcd_pkg::SCOPE_REGION;
               cmd.start    = 1'b1;
               cmd.size     = n_eff;
               state_in     = T_CHECK;
            end
         end
         T_CHECK: begin
            if (sts.done) begin
               dl_in = sts.found;
               if ((scope_ff == hwcd_pkg::SCOPE_REGION) && sts.found) begin
                  mu_in    = '0;
                  state_in = T_MERGE;
               end else begin
                  state_in = T_EMIT;
               end
            end
         end
         T_MERGE: begin
            glb_we = m_pend_ff;
            if (mu_ff < n_ff) begin
               m_pend_in = 1'b1;
               m_addr_in = mu_ff[hwcd_pkg::NODE_W-1:0];
               mu_in     = mu_ff + 1'b1;
            end else if (!m_pend_ff) begin
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            if (emit_go) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.scope    = scope_ff;
               rsp_data_in.deadlock = dl_ff;
               rsp_data_in.last     = (scope_ff == hwcd_pkg::SCOPE_GLOBAL) || !close_all_ff;
               if (scope_ff == hwcd_pkg::SCOPE_REGION) begin
                  reg_clr = 1'b1;
                  if (close_all_ff) begin
                     scope_in  = hwcd_pkg::SCOPE_GLOBAL;
                     n_in      = hwcd_pkg::CNT_W'(hwcd_pkg::NODES);
                     cmd.start = 1'b1;
                     cmd.size  = hwcd_pkg::CNT_W'(hwcd_pkg::NODES);
                     state_in  = T_CHECK;
                  end else begin
                     state_in = T_IDLE;
                  end
               end else begin
                  glb_clr  = 1'b1;
                  state_in = T_IDLE;
               end
            end
         end
      endcase
   end

   // Control registers and per-row valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         m_pend_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reg_vld_ff   <= '0;
         glb_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         m_pend_ff    <= m_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (reg_clr) begin
            reg_vld_ff <= '0;
         end else if (reg_we) begin
            reg_vld_ff[req_payload.row_index] <= 1'b1;
         end
         if (glb_clr) begin
            glb_vld_ff <= '0;
         end else if (glb_we) begin
            glb_vld_ff[m_addr_ff] <= 1'b1;
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      scope_ff     <= scope_in;
      close_all_ff <= close_all_in;
      dl_ff        <= dl_in;
      mu_ff        <= mu_in;
      m_addr_ff    <= m_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Graph memories: one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (reg_we) begin
         region_mem[req_payload.row_index] <= reg_wdata;
      end
      if (glb_we) begin
         global_mem[m_addr_ff] <= glb_wdata;
      end
      reg_rd_ff <= region_mem[rd_addr];
      glb_rd_ff <= global_mem[rd_addr];
      reg_rv_ff <= reg_vld_ff[rd_addr];
      glb_rv_ff <= glb_vld_ff[rd_addr];
   end

   hwcd_dfs u_dfs (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .rd_row (dfs_row),
      .sts    (sts)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // The search finishes only while the controller waits for it.
   a_done_in_check: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> (state_ff == T_CHECK))
      else $error("search completion outside the check phase");

   // The merge never reads the row it is writing back in the same cycle.
   a_merge_no_overlap: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == T_MERGE) && m_pend_ff && (mu_ff < n_ff)) |->
      (mu_ff[hwcd_pkg::NODE_W-1:0] != m_addr_ff))
      else $error("merge read and write hit the same row");

   // After a region verdict beat is loaded the region graph is empty.
   a_region_cleared: assert property (@(posedge clock) disable iff (reset)
      (emit_go && (scope_ff == hwcd_pkg::SCOPE_REGION)) |=> (reg_vld_ff == '0))
      else $error("region graph not cleared after its verdict");

   // A global verdict belongs only to a request that closed the last region.
   a_global_needs_close: assert property (@(posedge clock) disable iff (reset)
      (emit_go && (scope_ff == hwcd_pkg::SCOPE_GLOBAL)) |-> close_all_ff)
      else $error("global verdict without last region");

endmodule

// ===== rtl/core/hwcd_dfs.sv =====
// Depth-first cycle search over a graph held in an external synchronous memory.
// Fetches one adjacency row at a time; uses types and helpers from hwcd_pkg.
module hwcd_dfs (
   input  logic                         clock,
   input  logic                         reset,
   input  hwcd_pkg::dfs_cmd_type        cmd,
   input  logic [hwcd_pkg::NODES-1:0]   rd_row,
   output hwcd_pkg::dfs_sts_type        sts
);

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_ROOT = 2'd1;
   localparam logic [1:0] D_WAIT = 2'd2;
   localparam logic [1:0] D_SCAN = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [hwcd_pkg::CNT_W-1:0]     size_ff, size_in;
   logic [hwcd_pkg::CNT_W-1:0]     root_ff, root_in;
   logic [hwcd_pkg::NODE_W-1:0]    sp_ff, sp_in;
   logic [hwcd_pkg::NODES-1:0]     visited_ff, visited_in;
   logic [hwcd_pkg::NODES-1:0]     onpath_ff, onpath_in;
   logic [hwcd_pkg::NODES-1:0]     row_ff, row_in;
   logic                           done_ff, done_in;
   logic                           found_ff, found_in;
   logic [hwcd_pkg::NODE_W-1:0]    stack_ff [hwcd_pkg::NODES];
   logic [hwcd_pkg::CNT_W-1:0]     next_ff  [hwcd_pkg::NODES];

   logic                           push;
   logic [hwcd_pkg::NODE_W-1:0]    push_at;
   logic [hwcd_pkg::NODE_W-1:0]    push_node;
   logic                           step;
   logic [hwcd_pkg::NODE_W-1:0]    rd_addr;
   logic [hwcd_pkg::NODE_W-1:0]    node;
   logic [hwcd_pkg::CNT_W-1:0]     nbr;
   logic [hwcd_pkg::NODE_W-1:0]    nbr_idx;
   logic [hwcd_pkg::NODE_W-1:0]    root_idx;

   assign node     = stack_ff[sp_ff];
   assign nbr      = next_ff[sp_ff];
   assign nbr_idx  = nbr[hwcd_pkg::NODE_W-1:0];
   assign root_idx = root_ff[hwcd_pkg::NODE_W-1:0];

   // Search sequencer: one neighbour examined per scan cycle.
   always_comb begin
      state_in   = state_ff;
      size_in    = size_ff;
      root_in    = root_ff;
      sp_in      = sp_ff;
      visited_in = visited_ff;
      onpath_in  = onpath_ff;
      row_in     = row_ff;
      done_in    = 1'b0;
      found_in   = found_ff;
      push       = 1'b0;
      push_at    = sp_ff;
      push_node  = root_idx;
      step       = 1'b0;
      rd_addr    = node;
      unique case (state_ff)
         D_IDLE: begin
            if (cmd.start) begin
               size_in    = cmd.size;
               root_in    = '0;
               visited_in = '0;
               onpath_in  = '0;
               found_in   = 1'b0;
               state_in   = D_ROOT;
            end
         end
         D_ROOT: begin
            if (root_ff >= size_ff) begin
               done_in  = 1'b1;
               found_in = 1'b0;
               state_in = D_IDLE;
            end else if (visited_ff[root_idx]) begin
               root_in = root_ff + 1'b1;
            end else begin
               push       = 1'b1;
               push_at    = '0;
               push_node  = root_idx;
               sp_in      = '0;
               visited_in = visited_ff | (hwcd_pkg::NODES'(1) << root_idx);
               onpath_in  = onpath_ff | (hwcd_pkg::NODES'(1) << root_idx);
               rd_addr    = root_idx;
               state_in   = D_WAIT;
            end
         end
         D_WAIT: begin
            row_in   = rd_row & hwcd_pkg::low_mask(size_ff);
            state_in = D_SCAN;
         end
         D_SCAN: begin
            if (nbr >= size_ff) begin
               // All neighbours done: leave the path and return to the parent, or at the root move on to the next root.
               onpath_in = onpath_ff & ~(hwcd_pkg::NODES'(1) << node);
               if (sp_ff == '0) begin
                  root_in  = root_ff + 1'b1;
                  state_in = D_ROOT;
               end else begin
                  sp_in    = sp_ff - 1'b1;
                  rd_addr  = stack_ff[sp_ff - 1'b1];
                  state_in = D_WAIT;
               end
            end else begin
               step = 1'b1;
               if (row_ff[nbr_idx]) begin
                  if (onpath_ff[nbr_idx]) begin
                     // A back edge closes a cycle.
                     done_in  = 1'b1;
                     found_in = 1'b1;
                     state_in = D_IDLE;
                  end else if (!visited_ff[nbr_idx] &&
                               (sp_ff != hwcd_pkg::NODE_W'(hwcd_pkg::NODES - 1))) begin
                     push       = 1'b1;
                     push_at    = sp_ff + 1'b1;
                     push_node  = nbr_idx;
                     sp_in      = sp_ff + 1'b1;
                     visited_in = visited_ff | (hwcd_pkg::NODES'(1) << nbr_idx);
                     onpath_in  = onpath_ff | (hwcd_pkg::NODES'(1) << nbr_idx);
                     rd_addr    = nbr_idx;
                     state_in   = D_WAIT;
                  end
               end
            end
         end
      endcase
   end

   // Control registers and the visited and on-path marks.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= D_IDLE;
         done_ff    <= 1'b0;
         found_ff   <= 1'b0;
         visited_ff <= '0;
         onpath_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         done_ff    <= done_in;
         found_ff   <= found_in;
         visited_ff <= visited_in;
         onpath_ff  <= onpath_in;
      end
   end

   // Search registers; the stack needs no reset as every entry is pushed before use.
   always_ff @(posedge clock) begin
      size_ff    <= size_in;
      root_ff    <= root_in;
      sp_ff      <= sp_in;
      row_ff     <= row_in;
      for (int k = 0; k < hwcd_pkg::NODES; k++) begin
         if (push && (push_at == hwcd_pkg::NODE_W'(k))) begin
            stack_ff[k] <= push_node;
            next_ff[k]  <= '0;
         end else if (step && (sp_ff == hwcd_pkg::NODE_W'(k))) begin
            next_ff[k] <= nbr + 1'b1;
         end
      end
   end

   assign sts.done    = done_ff;
   assign sts.found   = found_ff;
   assign sts.rd_addr = rd_addr;

   // A node on the current path has always been visited.
   a_path_visited: assert property (@(posedge clock) disable iff (reset)
      (onpath_ff & ~visited_ff) == '0)
      else $error("on-path node not marked visited");

   // Completion is reported only once the sequencer has gone idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == D_IDLE))
      else $error("search done while still active");

endmodule
